/* hw/rtl/tijm_pkg.sv */
// ----------------------------------------------------------------------------
// tijm_pkg
// Shared types and constants of the track id match join block.
// ----------------------------------------------------------------------------
package tijm_pkg;

    localparam int KEY_W = 31;
    localparam int IDX_W = 12;
    localparam int CNT_W = 13;

    localparam logic [31:0] HASH_MULT = 32'h9E37_79B1;
    localparam logic [CNT_W-1:0] MATCH_MAX = {CNT_W{1'b1}};

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_BUILD = 2'd1,
        CMD_PROBE = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_SKIPPED  = 2'd1,
        ST_FULL     = 2'd2,
        ST_OVERFLOW = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] track_id;
    } t_in_word;

    typedef struct packed {
        logic             matched;
        logic [IDX_W-1:0] newer_index;
        logic [IDX_W-1:0] older_index;
        logic [CNT_W-1:0] match_count;
        logic [1:0]       status;
    } t_out_word;

    // one table slot as kept in memory
    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [IDX_W-1:0] pos;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

/* hw/rtl/track_id_match_join.sv */
// ----------------------------------------------------------------------------
// track_id_match_join
// Joins keypoints of two frames by track id through a hash table in RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid/o_in_ready/i_in_word) takes one command word:
//   clear, build (newer-frame id) or probe (older-frame id). Every word gives
//   exactly one result word on the output channel (o_out_valid/i_out_ready/
//   o_out_word), in order.
//   One word is worked on at a time. Negative ids, overflowed positions and
//   unknown commands go from S_IDLE straight to S_DONE, which loads the
//   output register. Build and probe words pass S_HASH, S_READ and S_CMP
//   before S_DONE and walk the table by linear probing: one slot when the
//   home slot is empty or holds the id, up to TABLE_DEPTH. Hashing is done
//   in registered steps: hash multiply, reciprocal multiply and
//   multiply-subtract for the remainder; each probed slot costs one RAM read.
//   After reset and after each clear command the block sweeps the table RAM,
//   one slot per cycle, with o_in_ready low. A clear's result word is
//   offered when its sweep is done.
//   The output register holds a result while the receiver stalls; the next
//   input word may be taken meanwhile, but its result waits for the register.
// ----------------------------------------------------------------------------
module track_id_match_join #(
    parameter int TABLE_DEPTH   = 4096,
    parameter int MAX_KEYPOINTS = 4096
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  tijm_pkg::t_in_word   i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output tijm_pkg::t_out_word  o_out_word
);
    import tijm_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int PW = $clog2(MAX_KEYPOINTS + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_DEPTH - 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CLEAR = 6'b000010,
        S_HASH  = 6'b000100,
        S_READ  = 6'b001000,
        S_CMP   = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state           r_state, n_state;
    logic [KEY_W-1:0] r_key, n_key;
    logic             r_is_build, n_is_build;
    logic [AW-1:0]    r_slot, n_slot;
    logic [AW-1:0]    r_steps, n_steps;
    t_out_word        r_res, n_res;
    logic [PW-1:0]    r_newer_pos, n_newer_pos;
    logic [PW-1:0]    r_older_pos, n_older_pos;
    logic [AW:0]      r_entries, n_entries;
    logic [CNT_W-1:0] r_matches, n_matches;
    logic [AW-1:0]    r_clr_addr, n_clr_addr;
    logic             r_clr_reply, n_clr_reply;
    logic             r_out_valid, n_out_valid;
    t_out_word        r_out_word, n_out_word;

    logic             in_acc;
    logic             hash_start;
    logic             hash_done;
    logic [AW-1:0]    hash_slot;
    logic [AW-1:0]    slot_next;
    logic             ram_we, ram_re;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    t_entry           ram_wdata, ram_rdata;
    logic [PW-1:0]    pos;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign slot_next  = (r_slot == LAST_SLOT) ? '0 : r_slot + 1'b1;

    tijm_hash #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (hash_start),
        .i_key   (i_in_word.track_id[KEY_W-1:0]),
        .o_done  (hash_done),
        .o_slot  (hash_slot)
    );

    tijm_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_key       = r_key;
        n_is_build  = r_is_build;
        n_slot      = r_slot;
        n_steps     = r_steps;
        n_res       = r_res;
        n_newer_pos = r_newer_pos;
        n_older_pos = r_older_pos;
        n_entries   = r_entries;
        n_matches   = r_matches;
        n_clr_addr  = r_clr_addr;
        n_clr_reply = r_clr_reply;
        n_out_valid = r_out_valid;
        n_out_word  = r_out_word;
        hash_start  = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = r_slot;
        ram_wdata   = '0;
        ram_re      = 1'b0;
        ram_raddr   = r_slot;
        pos         = '0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_res      = '0;
                    n_key      = i_in_word.track_id[KEY_W-1:0];
                    n_is_build = (i_in_word.cmd == CMD_BUILD);
                    n_state    = S_DONE;
                    unique case (t_cmd'(i_in_word.cmd))
                        CMD_CLEAR: begin
                            n_newer_pos = '0;
                            n_older_pos = '0;
                            n_entries   = '0;
                            n_matches   = '0;
                            n_clr_addr  = '0;
                            n_clr_reply = 1'b1;
                            n_state     = S_CLEAR;
                        end
                        CMD_BUILD, CMD_PROBE: begin
                            pos = (i_in_word.cmd == CMD_BUILD) ? r_newer_pos : r_older_pos;
                            if (pos >= PW'(MAX_KEYPOINTS)) begin
                                n_res.status = ST_OVERFLOW;
                            end else begin
                                if (i_in_word.cmd == CMD_BUILD) begin
                                    n_newer_pos       = r_newer_pos + 1'b1;
                                    n_res.newer_index = IDX_W'(pos);
                                end else begin
                                    n_older_pos       = r_older_pos + 1'b1;
                                    n_res.older_index = IDX_W'(pos);
                                end
                                if (i_in_word.track_id[31]) begin
                                    n_res.status = ST_SKIPPED;
                                end else begin
                                    hash_start = 1'b1;
                                    n_state    = S_HASH;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_CLEAR: begin
                ram_we     = 1'b1;
                ram_waddr  = r_clr_addr;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == LAST_SLOT) begin
                    n_state     = r_clr_reply ? S_DONE : S_IDLE;
                    n_clr_reply = 1'b0;
                end
            end
            S_HASH: begin
                if (hash_done) begin
                    n_slot  = hash_slot;
                    n_steps = '0;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                ram_re  = 1'b1;
                n_state = S_CMP;
            end
            S_CMP: begin
                if (!ram_rdata.valid) begin
                    // empty slot ends the walk: insert on build, miss on probe
                    n_state = S_DONE;
                    if (r_is_build) begin
                        if (r_entries >= (AW+1)'(TABLE_DEPTH)) begin
                            n_res.status = ST_FULL;
                        end else begin
                            ram_we          = 1'b1;
                            ram_wdata.valid = 1'b1;
                            ram_wdata.key   = r_key;
                            ram_wdata.pos   = r_res.newer_index;
                            n_entries       = r_entries + 1'b1;
                        end
                    end
                end else if (ram_rdata.key == r_key) begin
                    n_state = S_DONE;
                    if (!r_is_build) begin
                        n_res.matched     = 1'b1;
                        n_res.newer_index = ram_rdata.pos;
                        if (r_matches != MATCH_MAX) begin
                            n_matches = r_matches + 1'b1;
                        end
                    end
                end else if (r_steps == LAST_SLOT) begin
                    // whole table walked without a hit or a hole
                    n_state = S_DONE;
                    if (r_is_build) begin
                        n_res.status = ST_FULL;
                    end
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = slot_next;
                    n_slot    = slot_next;
                    n_steps   = r_steps + 1'b1;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid            = 1'b1;
                    n_out_word             = r_res;
                    n_out_word.match_count = r_matches;
                    n_state                = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_clr_reply <= 1'b0;
            r_newer_pos <= '0;
            r_older_pos <= '0;
            r_entries   <= '0;
            r_matches   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_clr_reply <= n_clr_reply;
            r_newer_pos <= n_newer_pos;
            r_older_pos <= n_older_pos;
            r_entries   <= n_entries;
            r_matches   <= n_matches;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key      <= n_key;
        r_is_build <= n_is_build;
        r_slot     <= n_slot;
        r_steps    <= n_steps;
        r_res      <= n_res;
        r_out_word <= n_out_word;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

/* hw/rtl/tijm_ram.sv */
// ----------------------------------------------------------------------------
// tijm_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tijm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/tijm_hash.sv */
// ----------------------------------------------------------------------------
// tijm_hash
// Home slot of a key: multiplicative hash, then remainder by the table
// depth through a reciprocal multiply. Start passes r_v1, r_v2 and r_done.
// ----------------------------------------------------------------------------
module tijm_hash #(
    parameter int TABLE_DEPTH = 4096
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [tijm_pkg::KEY_W-1:0]     i_key,
    output logic                           o_done,
    output logic [$clog2(TABLE_DEPTH)-1:0] o_slot
);
    import tijm_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int SH = 32 + AW;
    // floor(h / depth) == (h * RECIP) >> SH for every 32-bit h
    localparam logic [32:0] RECIP   = 33'(((65'(1) << SH) / 65'(TABLE_DEPTH)) + 65'(1));
    localparam logic [31:0] DEPTH_C = 32'(TABLE_DEPTH);

    logic [31:0]   r_hash;
    logic [31:0]   r_quot;
    logic [AW-1:0] r_rem;
    logic          r_v1;
    logic          r_v2;
    logic          r_done;
    logic [64:0]   prod;
    logic [31:0]   back;

    assign prod = {33'd0, r_hash} * {32'd0, RECIP};
    assign back = 32'(r_quot * DEPTH_C);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_v1   <= i_start;
            r_v2   <= r_v1;
            r_done <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_hash <= 32'({1'b0, i_key} * HASH_MULT) ^ 32'(i_key >> 15);
        end
        if (r_v1) begin
            r_quot <= 32'(prod >> SH);
        end
        if (r_v2) begin
            r_rem <= AW'(r_hash - back);
        end
    end

    assign o_done = r_done;
    assign o_slot = r_rem;

endmodule

/* hw/rtl/tijm_checker.sv */
// ----------------------------------------------------------------------------
// tijm_checker
// Port level checks of the track id match join block, bound to the top.
// ----------------------------------------------------------------------------
module tijm_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input tijm_pkg::t_in_word  i_in_word,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input tijm_pkg::t_out_word o_out_word
);
    import tijm_pkg::*;

    // table sweep follows reset, so input is not ready right after reset
    a_reset_sweep: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready)
        else $error("input ready right after reset");

    // one word in flight at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second word taken while one is in flight");

    a_match_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.matched) |->
            (o_out_word.status == ST_OK && o_out_word.match_count != '0))
        else $error("match word with bad status or zero count");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("output word dropped before taken");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> $stable(o_out_word))
        else $error("output word changed while stalled");

endmodule

bind track_id_match_join tijm_checker u_tijm_checker (.*);
